[src/vbsd_pkg.sv]
// Shared types and constants for the varint byte stream decoder.
// No dependencies; used by the interfaces, the top level and the checker.
package vbsd_pkg;

   // Payload widths
   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned VALUE_W = 64;
   localparam int unsigned STAT_W  = 2;
   localparam int unsigned CNT_W   = 4;

   typedef logic [BYTE_W-1:0]  byte_type;
   typedef logic [VALUE_W-1:0] value_type;
   typedef logic [STAT_W-1:0]  status_type;
   typedef logic [CNT_W-1:0]   count_type;

   // Lead byte layout
   localparam int unsigned LEAD_FLAG_BIT = 7;
   localparam int unsigned LEN_LSB       = 5;
   localparam int unsigned HIGH_W        = 5;

   typedef logic [1:0] len_code_type;
   localparam len_code_type LEN_CODE_LONG = 2'd3;

   // Continuation bytes owed by the long form
   localparam count_type LONG_BYTES = 4'd8;

   // Result status codes
   localparam status_type STAT_DONE  = 2'd0;
   localparam status_type STAT_END   = 2'd1;
   localparam status_type STAT_TRUNC = 2'd2;

endpackage

[src/vbsd_if.sv]
// Valid/ready channel interfaces for the decoder's request and response beats.
// Depends on vbsd_pkg for payload types.

interface vbsd_req_if;
   logic               valid;
   logic               ready;
   vbsd_pkg::byte_type data_byte;
   logic               end_of_stream;

   modport source (output valid, output data_byte, output end_of_stream, input ready);
   modport sink   (input valid, input data_byte, input end_of_stream, output ready);
endinterface

interface vbsd_rsp_if;
   logic                 valid;
   logic                 ready;
   vbsd_pkg::value_type  value;
   vbsd_pkg::status_type status;

   modport source (output valid, output value, output status, input ready);
   modport sink   (input valid, input value, input status, output ready);
endinterface

[src/varint_byte_stream_decoder_unit.sv]
// Varint byte stream decoder: one coded byte per beat in, one decoded value out.
// Depends on vbsd_pkg and the channel interfaces in vbsd_if.sv.
//
//   channel  | direction | payload                          | handshake
//   ---------+-----------+----------------------------------+-------------
//   req_ch   | in        | data_byte[7:0], end_of_stream    | valid/ready
//   rsp_ch   | out       | value[63:0], status[1:0]         | valid/ready
//
// One request beat per cycle while req_ch.ready is high; the beat that completes
// a result (plain byte, last continuation byte, or end marker) registers it.
// The only loop is the accumulator/count register pair, updated once a beat.
// req_ch.ready is low only while a result waits and rsp_ch.ready is low.
// Synchronous active-high reset clears the open value and the output valid.
module varint_byte_stream_decoder_unit (
   input logic         clock,
   input logic         reset,
   vbsd_req_if.sink    req_ch,
   vbsd_rsp_if.source  rsp_ch
);

   vbsd_pkg::value_type  acc_ff, acc_in;
   vbsd_pkg::count_type  cnt_ff, cnt_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   vbsd_pkg::value_type  rsp_value_ff, rsp_value_in;
   vbsd_pkg::status_type rsp_status_ff, rsp_status_in;

   logic                 accept;
   logic                 emit;
   vbsd_pkg::value_type  emit_value;
   vbsd_pkg::status_type emit_status;
   vbsd_pkg::len_code_type len_code;
   vbsd_pkg::value_type  shifted;

   // Input side stalls only when the result register is full and held
   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign accept       = req_ch.valid && req_ch.ready;

   assign len_code = req_ch.data_byte[vbsd_pkg::LEN_LSB +: 2];
   assign shifted  = {acc_ff[vbsd_pkg::VALUE_W-vbsd_pkg::BYTE_W-1:0], req_ch.data_byte};

   // Decode one beat against the open-value state
   always_comb begin
      acc_in      = acc_ff;
      cnt_in      = cnt_ff;
      emit        = 1'b0;
      emit_value  = '0;
      emit_status = vbsd_pkg::STAT_DONE;
      if (accept) begin
         priority if (req_ch.end_of_stream) begin
            emit        = 1'b1;
            emit_status = (cnt_ff != '0) ? vbsd_pkg::STAT_TRUNC : vbsd_pkg::STAT_END;
            acc_in      = '0;
            cnt_in      = '0;
         end else if (cnt_ff == '0) begin
            if (!req_ch.data_byte[vbsd_pkg::LEAD_FLAG_BIT]) begin
               // short form: the byte is the value
               emit       = 1'b1;
               emit_value = vbsd_pkg::value_type'(req_ch.data_byte);
            end else if (len_code == vbsd_pkg::LEN_CODE_LONG) begin
               acc_in = '0;
               cnt_in = vbsd_pkg::LONG_BYTES;
            end else begin
               acc_in = vbsd_pkg::value_type'(req_ch.data_byte[vbsd_pkg::HIGH_W-1:0]);
               cnt_in = vbsd_pkg::count_type'(len_code) + vbsd_pkg::count_type'(1);
            end
         end else begin
            // continuation byte, most significant first
            cnt_in = cnt_ff - vbsd_pkg::count_type'(1);
            if (cnt_ff == vbsd_pkg::count_type'(1)) begin
               emit       = 1'b1;
               emit_value = shifted;
               acc_in     = '0;
            end else begin
               acc_in = shifted;
            end
         end
      end
   end

   // Result register next state
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      if (emit) begin
         rsp_valid_in  = 1'b1;
         rsp_value_in  = emit_value;
         rsp_status_in = emit_status;
      end else if (rsp_ch.ready) begin
         rsp_valid_in  = 1'b0;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         acc_ff       <= acc_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_ch.valid  = rsp_valid_ff;
   assign rsp_ch.value  = rsp_value_ff;
   assign rsp_ch.status = rsp_status_ff;

endmodule

[src/vbsd_checker.sv]
// Port-level checker for the varint decoder, attached by bind below.
// Depends on vbsd_pkg and the top level varint_byte_stream_decoder_unit.
module vbsd_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 req_end_of_stream,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input vbsd_pkg::value_type  rsp_value,
   input vbsd_pkg::status_type rsp_status
);

   // An end marker beat always yields a result on the next cycle
   a_end_gives_result: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_end_of_stream) |=> rsp_valid)
      else $error("end marker beat produced no result");

   // Non-value statuses carry a zero value
   a_status_zero_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != vbsd_pkg::STAT_DONE) |-> (rsp_value == '0))
      else $error("status beat with nonzero value");

   // Status code stays within the defined set
   a_status_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == vbsd_pkg::STAT_DONE ||
                     rsp_status == vbsd_pkg::STAT_END ||
                     rsp_status == vbsd_pkg::STAT_TRUNC))
      else $error("undefined status code");

   // A stalled result beat holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_value) && $stable(rsp_status)))
      else $error("stalled result beat changed");

endmodule

bind varint_byte_stream_decoder_unit vbsd_checker u_vbsd_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_ch.valid),
   .req_ready         (req_ch.ready),
   .req_end_of_stream (req_ch.end_of_stream),
   .rsp_valid         (rsp_ch.valid),
   .rsp_ready         (rsp_ch.ready),
   .rsp_value         (rsp_ch.value),
   .rsp_status        (rsp_ch.status)
);
